FILE: rtl/crc8pf_pkg.sv
// ----------------------------------------------------------------------------
// crc8pf_pkg
// Types, constants and the CRC-8 byte update shared by the frame builder.
// ----------------------------------------------------------------------------
package crc8pf_pkg;

   localparam logic [7:0] CRC_POLY    = 8'hD5;
   localparam logic [7:0] CRC_TOP     = 8'h80;
   localparam logic [7:0] HEADER_INIT = 8'hCC;

   localparam int         CSR_ADDR_W  = 3;
   localparam int         CSR_DATA_W  = 32;
   localparam logic       CSR_IDX_HEADER = 1'b0;

   // One body beat as it waits in the queue between front and back.
   typedef struct packed {
      logic [7:0] body_byte;
      logic       is_last;
      logic       first;
   } entry_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef enum logic [1:0] {
      ST_HEAD,
      ST_BODY,
      ST_TAIL
   } phase_type;

   // CRC-8, MSB first, no reflection and no final inversion.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((v & CRC_TOP) != 8'h00) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

endpackage

FILE: rtl/crc8pf_front.sv
// ----------------------------------------------------------------------------
// crc8pf_front
// Accepts body beats and marks the one that opens a frame.
// ----------------------------------------------------------------------------
module crc8pf_front
   import crc8pf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_body_byte,
   input  logic       req_is_last,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_entry
);

   logic in_frame_ff;
   logic in_frame_in;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_entry.body_byte = req_body_byte;
      push_entry.is_last   = req_is_last;
      push_entry.first     = !in_frame_ff;
   end

   // A frame stays open until a beat marked last has been taken.
   always_comb begin
      in_frame_in = in_frame_ff;
      if (push) begin
         in_frame_in = !req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

FILE: rtl/crc8pf_queue.sv
// ----------------------------------------------------------------------------
// crc8pf_queue
// Small first-in first-out store of classified beats.
// ----------------------------------------------------------------------------
module crc8pf_queue
   import crc8pf_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output head_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/crc8pf_back.sv
// ----------------------------------------------------------------------------
// crc8pf_back
// Expands queued beats into body bytes, with a header before the first and a CRC trailer after the last of each frame.
// ----------------------------------------------------------------------------
module crc8pf_back
   import crc8pf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   input  logic [7:0] header_byte,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   phase_type  state_ff, state_in;
   phase_type  cur_phase;
   logic [7:0] crc_ff, crc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       run_last_ff, run_last_in;
   logic       frame_end_ff, frame_end_in;
   logic       load_en;
   logic       emit;

   assign load_en = !rsp_valid_ff || !rsp_stall;
   assign emit    = load_en && head.valid;

   // A beat that continues a frame has no header to insert.
   always_comb begin
      cur_phase = state_ff;
      if (state_ff == ST_HEAD && !head.entry.first) begin
         cur_phase = ST_BODY;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (emit) begin
         case (cur_phase)
            ST_HEAD: state_in = ST_BODY;
            ST_BODY: state_in = head.entry.is_last ? ST_TAIL : ST_HEAD;
            ST_TAIL: state_in = ST_HEAD;
            default: state_in = ST_HEAD;
         endcase
      end
   end

   always_comb begin
      pop          = 1'b0;
      crc_in       = crc_ff;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      rsp_valid_in = load_en ? head.valid : rsp_valid_ff;
      if (emit) begin
         case (cur_phase)
            ST_HEAD: begin
               crc_in       = crc8_update(8'h00, header_byte);
               out_byte_in  = header_byte;
               run_last_in  = 1'b0;
               frame_end_in = 1'b0;
            end
            ST_BODY: begin
               crc_in       = crc8_update(crc_ff, head.entry.body_byte);
               out_byte_in  = head.entry.body_byte;
               run_last_in  = !head.entry.is_last;
               frame_end_in = 1'b0;
               pop          = !head.entry.is_last;
            end
            ST_TAIL: begin
               crc_in       = 8'h00;
               out_byte_in  = crc_ff;
               run_last_in  = 1'b1;
               frame_end_in = 1'b1;
               pop          = 1'b1;
            end
            default: begin
               crc_in = 8'h00;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HEAD;
         crc_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

FILE: rtl/crc8_packet_framer.sv
// ----------------------------------------------------------------------------
// crc8_packet_framer
// Builds CRC-8 protected control frames from a stream of body bytes.
// ----------------------------------------------------------------------------
// Each req beat carries one body byte and a flag marking the last byte of a
// frame. Before the first body byte of a frame the header byte from the
// register at address 0 is sent, and after the last one the CRC-8 (poly 0xD5)
// of header and body follows, flagged by rsp_frame_end. rsp_run_last marks
// the final rsp beat caused by a req beat.
// The front end takes one req beat per cycle, unless the queue is full,
// into a queue of QUEUE_DEPTH entries; the back end sends one rsp beat per
// cycle from its output register unless rsp_stall holds it or the queue is
// empty. Each result is loaded from the queue head into that register.
// req_stall rises only when the queue is full, which happens when the
// receiver stalls or while headers and trailers are being inserted.
// A stalled rsp beat holds its payload. Reset clears the queue, closes any
// open frame, zeroes the CRC and restores the header byte to 0xCC.
// ----------------------------------------------------------------------------
module crc8_packet_framer
   import crc8pf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_body_byte,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_frame_end,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [7:0] header_byte_ff, header_byte_in;
   logic       queue_full;
   logic       push;
   logic       pop;
   entry_type  push_entry;
   head_type   head;

   assign csr_pready = 1'b1;

   always_comb begin
      header_byte_in = header_byte_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == CSR_IDX_HEADER) begin
         header_byte_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_HEADER) begin
         csr_prdata = {{(CSR_DATA_W - 8){1'b0}}, header_byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= HEADER_INIT;
      end else begin
         header_byte_ff <= header_byte_in;
      end
   end

   crc8pf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_body_byte (req_body_byte),
      .req_is_last   (req_is_last),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   crc8pf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head       (head)
   );

   crc8pf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .header_byte   (header_byte_ff),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

FILE: rtl/crc8pf_checker.sv
// ----------------------------------------------------------------------------
// crc8pf_checker
// Port-level checks on the frame builder, bound to its top level.
// ----------------------------------------------------------------------------
module crc8pf_checker
   import crc8pf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [7:0]            rsp_out_byte,
   input logic                  rsp_run_last,
   input logic                  rsp_frame_end,
   input logic                  csr_pready
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_frame_end))
      else $error("rsp payload changed while stalled");

   // The trailer always closes the run of beats caused by an input.
   a_trailer_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("trailer without run_last");

   // After a trailer has gone, the next beat opens a new frame and so is no trailer.
   a_no_double_trailer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_frame_end |=> !(rsp_valid && rsp_frame_end))
      else $error("two trailers in a row");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

endmodule

bind crc8_packet_framer crc8pf_checker u_checker (.*);
